@@ hw/rtl/svh_pkg.sv @@
// Shared types, constants and helpers for the sorted value histogram.
`timescale 1ns / 1ps
`default_nettype none

package svh_pkg;

  // Field widths
  localparam int VALUE_BITS    = 16;
  localparam int COUNT_BITS    = 32;
  localparam int SHARE_BITS    = 14;
  localparam int BAR_BITS      = 8;
  localparam int REQ_BITS      = 2;

  // Table depth default
  localparam int TABLE_ENTRIES_DEF = 64;

  // Arithmetic constants
  localparam int FULL_SHARE = 10000;
  localparam logic [BAR_BITS-1:0] BAR_RESET = 8'd32;

  // Configuration port
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 32;
  localparam logic [0:0] REG_BAR_WIDTH = 1'b0;

  // Request codes
  typedef enum logic [REQ_BITS-1:0] {
    REQ_ADD   = 2'd0,
    REQ_DUMP  = 2'd1,
    REQ_CLEAR = 2'd2
  } req_type_t;

  // Chain operation broadcast to every cell
  typedef enum logic [1:0] {
    CH_HOLD,
    CH_ADD,
    CH_ROTATE,
    CH_CLEAR
  } chain_op_t;

  typedef struct packed {
    chain_op_t             op;
    logic [VALUE_BITS-1:0] sample;
    logic                  hit_any;
  } chain_ctrl_t;

  // Contents of one cell
  typedef struct packed {
    logic                  valid;
    logic [VALUE_BITS-1:0] key;
    logic [COUNT_BITS-1:0] count;
  } cell_t;

  // Divider request
  typedef struct packed {
    logic                  start;
    logic [COUNT_BITS-1:0] count;
    logic [COUNT_BITS-1:0] total;
    logic [BAR_BITS-1:0]   bar_width;
  } div_req_t;

  // Dump sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_EMIT,
    ST_SPIN
  } dump_state_t;

  // Saturating increment of a count
  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (&v) ? v : v + COUNT_BITS'(1);
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/svh_if.sv @@
// Valid/ready channel interfaces for request items and result items.
`timescale 1ns / 1ps
`default_nettype none

interface svh_in_if import svh_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [REQ_BITS-1:0]   req_type;
  logic [VALUE_BITS-1:0] sample_value;

  modport source (output valid, output req_type, output sample_value, input ready);
  modport sink   (input valid, input req_type, input sample_value, output ready);
endinterface

interface svh_out_if import svh_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] entry_value;
  logic [COUNT_BITS-1:0] entry_count;
  logic [SHARE_BITS-1:0] share_hundredths;
  logic [BAR_BITS-1:0]   bar_length;
  logic                  table_empty;
  logic                  overflow_seen;
  logic                  last;

  modport source (output valid, output entry_value, output entry_count,
                  output share_hundredths, output bar_length, output table_empty,
                  output overflow_seen, output last, input ready);
  modport sink   (input valid, input entry_value, input entry_count,
                  input share_hundredths, input bar_length, input table_empty,
                  input overflow_seen, input last, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/svh_cell.sv @@
// One table cell: holds a key and its count, matches, inserts and shifts.
`timescale 1ns / 1ps
`default_nettype none

module svh_cell import svh_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  chain_ctrl_t ctrl,
  input  cell_t       left_q,
  input  logic        left_ge,
  input  cell_t       right_q,
  output cell_t       cell_q,
  output logic        eq,
  output logic        ge
);

  logic                  valid_r, valid_nxt;
  logic [VALUE_BITS-1:0] key_r, key_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;

  assign cell_q = '{valid: valid_r, key: key_r, count: count_r};

  // Compare against the broadcast sample
  assign eq = valid_r && (key_r == ctrl.sample);
  assign ge = !valid_r || (key_r > ctrl.sample);

  // Pick the next contents
  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    count_nxt = count_r;
    unique case (ctrl.op)
      CH_ADD: begin
        if (ctrl.hit_any) begin
          if (eq) begin
            count_nxt = sat_inc(count_r);
          end
        end else if (ge) begin
          if (left_ge) begin
            // make room: take the left neighbor
            valid_nxt = left_q.valid;
            key_nxt   = left_q.key;
            count_nxt = left_q.count;
          end else begin
            // first cell above the sample: insert here
            valid_nxt = 1'b1;
            key_nxt   = ctrl.sample;
            count_nxt = COUNT_BITS'(1);
          end
        end
      end
      CH_ROTATE: begin
        valid_nxt = right_q.valid;
        key_nxt   = right_q.key;
        count_nxt = right_q.count;
      end
      CH_CLEAR: begin
        valid_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Occupied flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Key and count
  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    count_r <= count_nxt;
  end

endmodule

`default_nettype wire

@@ hw/rtl/svh_div.sv @@
// Serial divider for share and bar length, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module svh_div import svh_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  div_req_t              req,
  output logic                  done,
  output logic [SHARE_BITS-1:0] share,
  output logic [BAR_BITS-1:0]   bar
);

  localparam int PROD_S_BITS = COUNT_BITS + SHARE_BITS;
  localparam int PROD_B_BITS = COUNT_BITS + BAR_BITS;
  localparam int STEP_BITS   = $clog2(SHARE_BITS + 1);
  localparam logic [STEP_BITS-1:0] BAR_FLOOR = STEP_BITS'(SHARE_BITS - BAR_BITS);

  logic [PROD_S_BITS-1:0] prod_s_r;
  logic [PROD_B_BITS-1:0] prod_b_r;
  logic [COUNT_BITS-1:0]  den_r;
  logic                   den_zero_r;
  logic                   load_r;
  logic [STEP_BITS-1:0]   steps_r;
  logic                   done_r;
  logic [COUNT_BITS-1:0]  rem_s_r, rem_b_r;
  logic [SHARE_BITS-1:0]  lo_s_r, q_s_r;
  logic [BAR_BITS-1:0]    lo_b_r, q_b_r;

  logic [COUNT_BITS:0] trial_s, trial_b, diff_s, diff_b;
  logic                fit_s, fit_b;

  // Trial subtract for both quotients
  assign trial_s = {rem_s_r, lo_s_r[SHARE_BITS-1]};
  assign trial_b = {rem_b_r, lo_b_r[BAR_BITS-1]};
  assign fit_s   = trial_s >= {1'b0, den_r};
  assign fit_b   = trial_b >= {1'b0, den_r};
  assign diff_s  = trial_s - {1'b0, den_r};
  assign diff_b  = trial_b - {1'b0, den_r};

  // Sequence control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_r  <= 1'b0;
      steps_r <= '0;
      done_r  <= 1'b0;
    end else begin
      load_r <= req.start;
      done_r <= (steps_r == STEP_BITS'(1));
      if (load_r) begin
        steps_r <= STEP_BITS'(SHARE_BITS);
      end else if (steps_r != '0) begin
        steps_r <= steps_r - STEP_BITS'(1);
      end
    end
  end

  // Products, then shift-subtract iterations
  always_ff @(posedge clk) begin
    if (req.start) begin
      prod_s_r   <= PROD_S_BITS'(req.count) * PROD_S_BITS'(FULL_SHARE);
      prod_b_r   <= PROD_B_BITS'(req.count) * PROD_B_BITS'(req.bar_width);
      den_r      <= req.total;
      den_zero_r <= (req.total == '0);
    end
    if (load_r) begin
      rem_s_r <= prod_s_r[PROD_S_BITS-1:SHARE_BITS];
      lo_s_r  <= prod_s_r[SHARE_BITS-1:0];
      q_s_r   <= '0;
      rem_b_r <= prod_b_r[PROD_B_BITS-1:BAR_BITS];
      lo_b_r  <= prod_b_r[BAR_BITS-1:0];
      q_b_r   <= '0;
    end else if (steps_r != '0) begin
      rem_s_r <= fit_s ? diff_s[COUNT_BITS-1:0] : trial_s[COUNT_BITS-1:0];
      lo_s_r  <= {lo_s_r[SHARE_BITS-2:0], 1'b0};
      q_s_r   <= {q_s_r[SHARE_BITS-2:0], fit_s};
      if (steps_r > BAR_FLOOR) begin
        rem_b_r <= fit_b ? diff_b[COUNT_BITS-1:0] : trial_b[COUNT_BITS-1:0];
        lo_b_r  <= {lo_b_r[BAR_BITS-2:0], 1'b0};
        q_b_r   <= {q_b_r[BAR_BITS-2:0], fit_b};
      end
    end
  end

  // Force zero on an empty total
  assign done  = done_r;
  assign share = den_zero_r ? '0 : q_s_r;
  assign bar   = den_zero_r ? '0 : q_b_r;

endmodule

`default_nettype wire

@@ hw/rtl/sorted_value_histogram.sv @@
// Sorted value histogram: add and clear items leave the block idle, so it
// is ready for the next item in the following cycle. The table is a chain of
// TABLE_ENTRIES cells kept in ascending order; a sample is compared in every
// cell at once, and a new value is inserted by shifting the cells above it one
// place up in the same cycle. A dump rotates the chain one place per entry and
// runs each entry through a serial divider (one quotient bit per cycle, 14
// bits for the share), then rotates once per unoccupied cell to bring the chain
// back into order. No item is accepted during a dump. Zero samples and unused
// request codes are dropped without effect. bar_width sits at byte address 0
// of the configuration port and resets to 32.
`timescale 1ns / 1ps
`default_nettype none

module sorted_value_histogram import svh_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  svh_in_if.sink                   in_ch,
  svh_out_if.source                out_ch,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_BITS-1:0] paddr,
  input  logic [CFG_DATA_BITS-1:0] pwdata,
  output logic [CFG_DATA_BITS-1:0] prdata,
  output logic                     pready
);

  localparam int ROT_BITS = $clog2(TABLE_ENTRIES + 1);
  localparam logic [ROT_BITS-1:0] ROT_LAST = ROT_BITS'(TABLE_ENTRIES - 1);
  localparam logic [ROT_BITS-1:0] ROT_END  = ROT_BITS'(TABLE_ENTRIES);

  // Configuration register
  logic [BAR_BITS-1:0] bar_width_r;
  logic                cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[CFG_ADDR_BITS-1:2] == REG_BAR_WIDTH);
  assign prdata = (paddr[CFG_ADDR_BITS-1:2] == REG_BAR_WIDTH) ?
                  CFG_DATA_BITS'(bar_width_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bar_width_r <= BAR_RESET;
    end else if (cfg_wr) begin
      bar_width_r <= pwdata[BAR_BITS-1:0];
    end
  end

  // Cell chain
  chain_ctrl_t              ctrl;
  cell_t                    cells_q [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] eq_v, ge_v;
  logic                     hit_any, full;

  assign hit_any = |eq_v;
  assign full    = cells_q[TABLE_ENTRIES-1].valid;

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    cell_t left_q;
    logic  left_ge;
    if (i == 0) begin : g_head
      assign left_q  = '0;
      assign left_ge = 1'b0;
    end else begin : g_body
      assign left_q  = cells_q[i-1];
      assign left_ge = ge_v[i-1];
    end
    svh_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (ctrl),
      .left_q  (left_q),
      .left_ge (left_ge),
      .right_q (cells_q[(i + 1) % TABLE_ENTRIES]),
      .cell_q  (cells_q[i]),
      .eq      (eq_v[i]),
      .ge      (ge_v[i])
    );
  end

  // Divider
  div_req_t              div_req;
  logic                  div_done;
  logic [SHARE_BITS-1:0] div_share;
  logic [BAR_BITS-1:0]   div_bar;

  svh_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .share (div_share),
    .bar   (div_bar)
  );

  // Sequencer and statistics state
  dump_state_t           state_r, state_nxt;
  logic [ROT_BITS-1:0]   rot_r, rot_nxt;
  logic [COUNT_BITS-1:0] total_r, total_nxt;
  logic                  ovf_r, ovf_nxt;
  logic [VALUE_BITS-1:0] cap_key_r;
  logic [COUNT_BITS-1:0] cap_count_r;
  logic                  cap_last_r, cap_empty_r;
  logic                  cap_en, div_start, out_load, out_free, in_fire;

  // Output register
  logic                  out_valid_r;
  logic [VALUE_BITS-1:0] out_value_r;
  logic [COUNT_BITS-1:0] out_count_r;
  logic [SHARE_BITS-1:0] out_share_r;
  logic [BAR_BITS-1:0]   out_bar_r;
  logic                  out_empty_r, out_ovf_r, out_last_r;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  assign div_req = '{start: div_start, count: cells_q[0].count, total: total_r,
                     bar_width: bar_width_r};

  // Next state and chain control
  always_comb begin
    state_nxt    = state_r;
    rot_nxt      = rot_r;
    total_nxt    = total_r;
    ovf_nxt      = ovf_r;
    cap_en       = 1'b0;
    div_start    = 1'b0;
    out_load     = 1'b0;
    ctrl.op      = CH_HOLD;
    ctrl.sample  = in_ch.sample_value;
    ctrl.hit_any = hit_any;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_ch.req_type)
            REQ_ADD: begin
              if (in_ch.sample_value != '0) begin
                if (hit_any || !full) begin
                  ctrl.op   = CH_ADD;
                  total_nxt = sat_inc(total_r);
                end else begin
                  ovf_nxt = 1'b1;
                end
              end
            end
            REQ_DUMP: begin
              state_nxt = ST_LOAD;
              rot_nxt   = '0;
            end
            REQ_CLEAR: begin
              ctrl.op   = CH_CLEAR;
              total_nxt = '0;
              ovf_nxt   = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_LOAD: begin
        // capture the head cell and rotate the next entry in
        cap_en = 1'b1;
        if (cells_q[0].valid) begin
          div_start = 1'b1;
          ctrl.op   = CH_ROTATE;
          rot_nxt   = rot_r + ROT_BITS'(1);
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (!cap_last_r) begin
            state_nxt = ST_LOAD;
          end else if (cap_empty_r || (rot_r == ROT_END)) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_SPIN;
          end
        end
      end
      ST_SPIN: begin
        // finish the full turn of the chain
        ctrl.op = CH_ROTATE;
        rot_nxt = rot_r + ROT_BITS'(1);
        if (rot_r == ROT_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rot_r       <= '0;
      total_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rot_r   <= rot_nxt;
      total_r <= total_nxt;
      ovf_r   <= ovf_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Capture the entry being dumped
  always_ff @(posedge clk) begin
    if (cap_en) begin
      cap_key_r   <= cells_q[0].key;
      cap_count_r <= cells_q[0].count;
      cap_empty_r <= !cells_q[0].valid;
      cap_last_r  <= !cells_q[0].valid || !cells_q[1].valid || (rot_r == ROT_LAST);
    end
  end

  // Load the result item
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_empty_r <= cap_empty_r;
      out_ovf_r   <= ovf_r;
      out_last_r  <= cap_last_r;
      if (cap_empty_r) begin
        out_value_r <= '0;
        out_count_r <= '0;
        out_share_r <= '0;
        out_bar_r   <= '0;
      end else begin
        out_value_r <= cap_key_r;
        out_count_r <= cap_count_r;
        out_share_r <= div_share;
        out_bar_r   <= div_bar;
      end
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.entry_value      = out_value_r;
  assign out_ch.entry_count      = out_count_r;
  assign out_ch.share_hundredths = out_share_r;
  assign out_ch.bar_length       = out_bar_r;
  assign out_ch.table_empty      = out_empty_r;
  assign out_ch.overflow_seen    = out_ovf_r;
  assign out_ch.last             = out_last_r;

endmodule

`default_nettype wire

@@ hw/rtl/svh_checker.sv @@
// Port-level checks for the sorted value histogram, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module svh_checker import svh_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic [REQ_BITS-1:0]   in_req_type,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [COUNT_BITS-1:0] out_entry_count,
  input logic [SHARE_BITS-1:0] out_share,
  input logic [BAR_BITS-1:0]   out_bar,
  input logic                  out_table_empty,
  input logic                  out_last
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  // An empty dump is a single zero item
  a_empty_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_table_empty |->
      out_last && (out_entry_count == '0) && (out_share == '0) && (out_bar == '0))
    else $error("empty dump item malformed");

  // Share stays within full scale
  a_share_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_share <= SHARE_BITS'(FULL_SHARE))
    else $error("share above full scale");

  // A dump blocks new items
  a_dump_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_req_type == REQ_DUMP) |=> !in_ready)
    else $error("item accepted right after dump request");

  // A non-final item on the result side means the dump is still running
  a_dump_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("input open while dump items pending");

endmodule

bind sorted_value_histogram svh_checker u_svh_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .in_req_type     (in_ch.req_type),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_entry_count (out_ch.entry_count),
  .out_share       (out_ch.share_hundredths),
  .out_bar         (out_ch.bar_length),
  .out_table_empty (out_ch.table_empty),
  .out_last        (out_ch.last)
);

`default_nettype wire

@@ sim/tb_sorted_value_histogram.sv @@
// Self-checking testbench for the sorted value histogram block.
`timescale 1ns / 1ps

module tb_sorted_value_histogram;
  import svh_pkg::*;

  localparam int TABLE_DEPTH = TABLE_ENTRIES_DEF;
  localparam int CYCLE_LIMIT = 5000000;
  // dump drains one cell per cycle after the last row comes out
  localparam int SETTLE_CYCLES = 2 * TABLE_DEPTH + 20;
  localparam logic [REQ_BITS-1:0] REQ_UNUSED = 2'd3;
  localparam logic [CFG_ADDR_BITS-1:0] BAR_ADDR = CFG_ADDR_BITS'(4 * REG_BAR_WIDTH);

  // One dump row as seen on the result channel
  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [COUNT_BITS-1:0] count;
    logic [SHARE_BITS-1:0] share;
    logic [BAR_BITS-1:0]   bar;
    logic                  empty;
    logic                  ovf;
    logic                  last;
  } row_t;

  function automatic string row_text(row_t r);
    return $sformatf("value=%h count=%0d share=%0d bar=%0d empty=%b ovf=%b last=%b",
                     r.value, r.count, r.share, r.bar, r.empty, r.ovf, r.last);
  endfunction

  // Sorted table tracker: mirrors the histogram and queues the dump rows due
  class histogram_tracker;
    logic [VALUE_BITS-1:0] keys [TABLE_DEPTH];
    logic [COUNT_BITS-1:0] hits [TABLE_DEPTH];
    int unsigned           used;
    logic [COUNT_BITS-1:0] total;
    logic                  ovf;
    logic [BAR_BITS-1:0]   bar_width;
    row_t                  rows_due[$];
    int unsigned           errors;
    int unsigned           rows_seen;
    int unsigned           dumps;
    int unsigned           full_dumps;

    function new();
      used = 0;
      total = '0;
      ovf = 1'b0;
      bar_width = BAR_RESET;
    endfunction

    function logic [COUNT_BITS-1:0] bump_count(logic [COUNT_BITS-1:0] c);
      return (&c) ? c : c + 1'b1;
    endfunction

    // Match or insert in sorted position; drop unseen values when full
    function void add_value(logic [VALUE_BITS-1:0] v);
      int unsigned pos;
      pos = 0;
      while (pos < used && keys[pos] < v) pos++;
      if (pos < used && keys[pos] == v) begin
        hits[pos] = bump_count(hits[pos]);
        total = bump_count(total);
        return;
      end
      if (used >= TABLE_DEPTH) begin
        ovf = 1'b1;
        return;
      end
      for (int k = used; k > pos; k--) begin
        keys[k] = keys[k-1];
        hits[k] = hits[k-1];
      end
      keys[pos] = v;
      hits[pos] = 1;
      used++;
      total = bump_count(total);
    endfunction

    // Queue one row per entry, or a single empty-table row
    function void dump_rows();
      row_t r;
      longint unsigned c;
      dumps++;
      if (ovf) full_dumps++;
      if (used == 0) begin
        r = '0;
        r.empty = 1'b1;
        r.ovf = ovf;
        r.last = 1'b1;
        rows_due.push_back(r);
        return;
      end
      for (int i = 0; i < used; i++) begin
        c = hits[i];
        r = '0;
        r.value = keys[i];
        r.count = hits[i];
        if (total != 0) begin
          r.share = SHARE_BITS'((c * FULL_SHARE) / total);
          r.bar = BAR_BITS'((longint'(bar_width) * c) / total);
        end
        r.ovf = ovf;
        r.last = (i + 1 == used);
        rows_due.push_back(r);
      end
    endfunction

    function void note_request(logic [REQ_BITS-1:0] code, logic [VALUE_BITS-1:0] sample);
      case (code)
        REQ_ADD: begin
          if (sample != 0) add_value(sample);
        end
        REQ_DUMP: dump_rows();
        REQ_CLEAR: begin
          used = 0;
          total = '0;
          ovf = 1'b0;
        end
        default: ;
      endcase
    endfunction

    function void check_result(row_t got);
      row_t want;
      rows_seen++;
      if (rows_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected row: %s", $time, row_text(got));
        return;
      end
      want = rows_due.pop_front();
      if (got !== want) begin
        errors++;
        $display("%0t: row mismatch", $time);
        $display("  expected %s", row_text(want));
        $display("  actual   %s", row_text(got));
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_ADDR_BITS-1:0] paddr;
  logic [CFG_DATA_BITS-1:0] pwdata;
  logic [CFG_DATA_BITS-1:0] prdata;
  logic pready;

  svh_in_if  in_bus ();
  svh_out_if out_bus ();

  histogram_tracker tracker = new();

  int unsigned counted;
  int unsigned gap_odds;
  int unsigned cycles;
  bit          calm;

  sorted_value_histogram #(
    .TABLE_ENTRIES(TABLE_DEPTH)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d rows outstanding", $time, tracker.rows_due.size());
      $display("FAILURE");
      $finish;
    end
  end

  // Check every row the block hands over
  always @(posedge clk) begin : watch_rows
    row_t got;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got.value = out_bus.entry_value;
      got.count = out_bus.entry_count;
      got.share = out_bus.share_hundredths;
      got.bar = out_bus.bar_length;
      got.empty = out_bus.table_empty;
      got.ovf = out_bus.overflow_seen;
      got.last = out_bus.last;
      tracker.check_result(got);
    end
  end

  // Stall the result side in random bursts, never in the calm phase
  initial begin
    out_bus.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (calm || $urandom_range(0, 2) != 0) begin
        out_bus.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end else begin
        out_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
    end
  end

  // Send one request item, with an optional idle burst ahead of it
  task automatic send_item(input logic [REQ_BITS-1:0] code,
                           input logic [VALUE_BITS-1:0] sample);
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.req_type <= code;
    in_bus.sample_value <= sample;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    tracker.note_request(code, sample);
    if ((code == REQ_ADD && sample != 0) || code == REQ_DUMP || code == REQ_CLEAR)
      counted++;
  endtask

  // Drop valid and wait out all rows plus the chain's return to order
  task automatic settle();
    in_bus.valid <= 1'b0;
    while (tracker.rows_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write bar_width, then read it back
  task automatic write_bar(input logic [BAR_BITS-1:0] width);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= BAR_ADDR;
    pwdata <= CFG_DATA_BITS'(width);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    tracker.bar_width = width;
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[BAR_BITS-1:0] !== width) begin
      tracker.errors++;
      $display("%0t: bar_width readback expected %0d actual %0d",
               $time, width, prdata[BAR_BITS-1:0]);
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Noise item: zero sample or unused request code
  task automatic send_noise();
    if ($urandom_range(0, 1) == 0) send_item(REQ_ADD, '0);
    else send_item(REQ_UNUSED, VALUE_BITS'($urandom));
  endtask

  // Fill to capacity or past it with mostly distinct values, then dump
  task automatic fill_table();
    int unsigned n;
    n = $urandom_range(TABLE_DEPTH, TABLE_DEPTH + 16);
    repeat (n) send_item(REQ_ADD, VALUE_BITS'($urandom_range(1, 65535)));
    send_item(REQ_DUMP, VALUE_BITS'($urandom));
  endtask

  // One random sequence: mostly adds from a small pool followed by a dump
  task automatic run_sequence();
    logic [VALUE_BITS-1:0] pool [6];
    int unsigned kind;
    int unsigned pool_size;
    int unsigned n;
    kind = $urandom_range(0, 9);
    gap_odds = calm ? 0 : ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(2, 6));
    if ($urandom_range(0, 4) == 0) send_item(REQ_CLEAR, VALUE_BITS'($urandom));
    if (kind <= 5) begin
      pool_size = $urandom_range(1, 6);
      for (int i = 0; i < 6; i++) begin
        case ($urandom_range(0, 3))
          0: pool[i] = VALUE_BITS'($urandom_range(1, 255));
          1: pool[i] = 16'hFFFF - VALUE_BITS'($urandom_range(0, 3));
          default: pool[i] = VALUE_BITS'($urandom_range(1, 65535));
        endcase
      end
      n = $urandom_range(3, 20);
      repeat (n) begin
        if ($urandom_range(0, 7) == 0) send_noise();
        send_item(REQ_ADD, pool[$urandom_range(0, pool_size - 1)]);
      end
    end else if (kind == 6) begin
      n = $urandom_range(10, 40);
      repeat (n) send_item(REQ_ADD, VALUE_BITS'($urandom_range(1, 65535)));
    end else if (kind == 7) begin
      send_item(REQ_CLEAR, VALUE_BITS'($urandom));
      n = $urandom_range(0, 4);
      repeat (n) send_item(REQ_ADD, VALUE_BITS'($urandom_range(1, 65535)));
    end else if (kind == 8) begin
      n = $urandom_range(1, 5);
      repeat (n) send_noise();
      send_item(REQ_BITS'($urandom_range(0, 3)), VALUE_BITS'($urandom));
    end else begin
      fill_table();
    end
    send_item(REQ_DUMP, VALUE_BITS'($urandom));
  endtask

  initial begin
    logic [BAR_BITS-1:0] bar_plan [5];
    bar_plan[0] = BAR_RESET;
    bar_plan[1] = 8'd1;
    bar_plan[2] = 8'd255;
    bar_plan[3] = BAR_BITS'($urandom_range(2, 254));
    bar_plan[4] = BAR_BITS'($urandom_range(1, 255));

    // Hold every input at a known value through reset
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.req_type = REQ_ADD;
    in_bus.sample_value = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    counted = 0;
    gap_odds = 0;
    cycles = 0;
    calm = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty dump, ignored items, field extremes, hits, clear
    send_item(REQ_DUMP, '0);
    send_item(REQ_ADD, '0);
    send_item(REQ_UNUSED, 16'hFFFF);
    send_item(REQ_ADD, 16'hFFFF);
    send_item(REQ_ADD, 16'h0001);
    send_item(REQ_ADD, 16'h8000);
    send_item(REQ_ADD, 16'hAAAA);
    send_item(REQ_ADD, 16'h0001);
    send_item(REQ_ADD, 16'h5555);
    send_item(REQ_ADD, 16'h7FFF);
    send_item(REQ_ADD, 16'hFFFF);
    send_item(REQ_ADD, 16'h0001);
    send_item(REQ_DUMP, 16'h1234);
    send_item(REQ_CLEAR, 16'hFFFF);
    send_item(REQ_DUMP, '0);
    send_item(REQ_ADD, 16'h00FF);
    send_item(REQ_ADD, 16'hFF00);
    send_item(REQ_DUMP, '0);
    send_item(REQ_CLEAR, '0);

    // Random phases, one bar_width setting each; the last runs without stalls
    for (int ph = 0; ph < 5; ph++) begin
      if (ph > 0) begin
        settle();
        write_bar(bar_plan[ph]);
      end
      calm = (ph == 4);
      if (ph == 2) begin
        gap_odds = 4;
        fill_table();
      end
      while (counted < (ph + 1) * 60) run_sequence();
    end

    settle();
    $display("Covered %0d counted items over 5 bar_width settings (last %0d).",
             counted, bar_plan[4]);
    $display("Checked %0d rows from %0d dumps, %0d of them with overflow set.",
             tracker.rows_seen, tracker.dumps, tracker.full_dumps);
    if (tracker.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
